FILE: src/spectrum_bar_falloff_rainbow_defines.svh
// assertion macros shared by the spectrum bar block
`ifndef SPECTRUM_BAR_FALLOFF_RAINBOW_DEFINES_SVH
`define SPECTRUM_BAR_FALLOFF_RAINBOW_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define SBFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define SBFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/sbfr_pkg.sv
// shared constants, types and helper functions of the spectrum bar block
package sbfr_pkg;

   // geometry
   localparam int COLUMNS         = 64;
   localparam int BINS_PER_COLUMN = 4;
   localparam int PANEL_ROWS      = 32;
   localparam int FRAME_BINS      = COLUMNS * BINS_PER_COLUMN;
   localparam int CNT_W           = $clog2(FRAME_BINS);
   localparam int COL_W           = $clog2(COLUMNS);

   // field widths
   localparam int MAG_W      = 24;
   localparam int Q_W        = 25;
   localparam int SPEED_W    = 16;
   localparam int ACCEL_W    = 17;
   localparam int COLIDX_W   = 6;
   localparam int LEN_W      = 5;
   localparam int COLOR_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   // config register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_START_SPEED  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_ACCEL_FACTOR = 1'd1;

   // config reset values
   localparam logic [SPEED_W-1:0] FALL_START_SPEED_RST  = 16'd32768;
   localparam logic [ACCEL_W-1:0] FALL_ACCEL_FACTOR_RST = 17'd72090;

   // reciprocal multipliers: x/6 and x/60 exact over the value ranges used
   localparam int                 RECIP6_SHIFT  = 26;
   localparam logic [MAG_W-1:0]   RECIP6        = 24'd11184811;
   localparam int                 TGT_W         = MAG_W - 2;
   localparam int                 RECIP60_SHIFT = 30;
   localparam logic [Q_W-1:0]     RECIP60       = 25'd17895698;
   localparam int                 DIV60_W       = 2 * Q_W - RECIP60_SHIFT;

   // rainbow sectors
   localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;

   localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   // clamp a 27-bit signed value into the signed Q8.16 range
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W+1:0] x);
      logic signed [Q_W-1:0] res;
      if ((x[Q_W+1:Q_W-1] == 3'b000) || (x[Q_W+1:Q_W-1] == 3'b111)) begin
         res = x[Q_W-1:0];
      end else if (x[Q_W+1]) begin
         res = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(Q_W-1){1'b1}}};
      end
      return res;
   endfunction

   // six-sector rainbow color of a column
   function automatic rgb_type rainbow(input logic [COL_W-1:0] col);
      logic [31:0] six_col;
      logic [31:0] rem;
      logic [31:0] t_full;
      logic [31:0] q_full;
      logic [2:0]  sector;
      logic [COLOR_W-1:0] t;
      logic [COLOR_W-1:0] q;
      rgb_type     res;
      six_col = 32'(col) * 32'd6;
      sector  = 3'(six_col / COLUMNS);
      rem     = six_col % COLUMNS;
      t_full  = (32'd255 * rem) / COLUMNS;
      q_full  = (32'd255 * (32'(COLUMNS) - rem)) / COLUMNS;
      t       = t_full[COLOR_W-1:0];
      q       = q_full[COLOR_W-1:0];
      case (sector)
         SECTOR_RED_YELLOW:   res = '{COLOR_FULL, t, '0};
         SECTOR_YELLOW_GREEN: res = '{q, COLOR_FULL, '0};
         SECTOR_GREEN_CYAN:   res = '{'0, COLOR_FULL, t};
         SECTOR_CYAN_BLUE:    res = '{'0, q, COLOR_FULL};
         SECTOR_BLUE_MAGENTA: res = '{t, '0, COLOR_FULL};
         default:             res = '{COLOR_FULL, '0, q};
      endcase
      return res;
   endfunction

endpackage

FILE: src/sbfr_if.sv
// stream interfaces for the bin input channel and the column result channel

// bin input channel
interface sbfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [sbfr_pkg::MAG_W-1:0]  bin_magnitude;
   logic                        first_bin;

   modport source (output valid, output bin_magnitude, output first_bin, input ready);
   modport sink   (input valid, input bin_magnitude, input first_bin, output ready);
endinterface

// column result channel
interface sbfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sbfr_pkg::COLIDX_W-1:0] column_index;
   logic [sbfr_pkg::LEN_W-1:0]    bar_length;
   logic [sbfr_pkg::COLOR_W-1:0]  red;
   logic [sbfr_pkg::COLOR_W-1:0]  green;
   logic [sbfr_pkg::COLOR_W-1:0]  blue;
   logic                          last_column;

   modport source (output valid, output column_index, output bar_length, output red,
                   output green, output blue, output last_column, input ready);
   modport sink   (input valid, input column_index, input bar_length, input red,
                   input green, input blue, input last_column, output ready);
endinterface

FILE: src/spectrum_bar_falloff_rainbow.sv
// spectrum bar block: bins to column heights with gravity falloff and rainbow color
//
// req_ch takes one FFT bin magnitude per item; first_bin marks bin zero of a frame.
// Every group of BINS_PER_COLUMN bins drives one column; only the last bin of a
// group produces a result on rsp_ch, the other bins are taken and dropped.
// csr_* writes fall_start_speed (index 0) and fall_accel_factor (index 1).
// Steps: column state read, multiply, state update and write-back, bar length and
// color; the result register then offers the item on rsp_ch.
// Throughput: one bin per cycle while rsp_ch is not stalled. The column state update is a
// read-modify-write of the height and velocity memories, so the last bin of a group that
// hits a column still in the first two stages waits until that column has been written
// back; in normal framing this never happens.
// Reset: all column heights and velocities read as zero (a valid bit per column),
// the bin counter clears and the registers take their defaults; no clearing pass.
// Stall: when rsp_ch.ready is low the result is held, the stages behind it keep
// filling and group-ending bins are taken until the pipeline is full; others always are.
`include "spectrum_bar_falloff_rainbow_defines.svh"

module spectrum_bar_falloff_rainbow (
   input  logic                              clock,
   input  logic                              reset,
   sbfr_req_if.sink                          req_ch,
   sbfr_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_en,
   input  logic [sbfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbfr_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int QW = sbfr_pkg::Q_W;
   localparam int CW = sbfr_pkg::COL_W;
   localparam int NW = sbfr_pkg::CNT_W;
   localparam int AW = sbfr_pkg::ACCEL_W;

   // config registers
   logic [sbfr_pkg::SPEED_W-1:0] speed_ff;
   logic [AW-1:0]                accel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= sbfr_pkg::FALL_START_SPEED_RST;
         accel_ff <= sbfr_pkg::FALL_ACCEL_FACTOR_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            sbfr_pkg::CSR_FALL_START_SPEED:  speed_ff <= csr_write_data[sbfr_pkg::SPEED_W-1:0];
            sbfr_pkg::CSR_FALL_ACCEL_FACTOR: accel_ff <= csr_write_data[AW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline occupancy and flow control
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic a_valid_in, b_valid_in, c_valid_in, d_valid_in;
   logic a_ready, b_ready, c_ready, d_ready;
   logic a_adv, b_adv, c_adv;
   logic req_fire, a_load;

   assign d_ready = !d_valid_ff || rsp_ch.ready;
   assign c_adv   = c_valid_ff && d_ready;
   assign c_ready = !c_valid_ff || d_ready;
   assign b_adv   = b_valid_ff && c_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_adv   = a_valid_ff && b_ready;
   assign a_ready = !a_valid_ff || b_ready;

   // bin counter and column select
   logic [NW-1:0] bin_cnt_ff, bin_cnt_in, bin_sel, bin_grp;
   logic [NW:0]   bin_nxt;
   logic [CW-1:0] col_in;
   logic          emit_in, hazard_in;

   assign bin_sel = req_ch.first_bin ? '0 : bin_cnt_ff;
   assign bin_nxt = {1'b0, bin_sel} + 1'b1;
   assign bin_grp = NW'(bin_sel % sbfr_pkg::BINS_PER_COLUMN);
   assign emit_in = (bin_grp == NW'(sbfr_pkg::BINS_PER_COLUMN - 1));
   assign col_in  = CW'(bin_sel / sbfr_pkg::BINS_PER_COLUMN);

   logic [CW-1:0] a_col_ff, b_col_ff, c_col_ff;

   // hold a group's last bin while its column is still being updated ahead of it
   assign hazard_in = (a_valid_ff && (a_col_ff == col_in)) ||
                      (b_valid_ff && (b_col_ff == col_in));
   assign req_ch.ready = !emit_in || (a_ready && !hazard_in);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign a_load       = req_fire && emit_in;

   always_comb begin
      bin_cnt_in = bin_cnt_ff;
      if (req_fire) begin
         bin_cnt_in = (bin_nxt >= (NW+1)'(sbfr_pkg::FRAME_BINS)) ? '0 : bin_nxt[NW-1:0];
      end
   end

   assign a_valid_in = a_load ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
   assign b_valid_in = a_adv  ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
   assign c_valid_in = b_adv  ? 1'b1 : (c_adv ? 1'b0 : c_valid_ff);
   assign d_valid_in = c_adv  ? 1'b1 : (rsp_ch.ready ? 1'b0 : d_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_cnt_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         bin_cnt_ff <= bin_cnt_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   // column state memories and per-column valid bits
   logic [QW-1:0]           height_mem [sbfr_pkg::COLUMNS];
   logic [QW-1:0]           velocity_mem [sbfr_pkg::COLUMNS];
   logic [sbfr_pkg::COLUMNS-1:0] col_valid_ff;
   logic [QW-1:0]           a_hraw_ff, a_vraw_ff;
   logic                    a_hit_ff;
   logic signed [QW-1:0]    new_h, new_v;

   always_ff @(posedge clock) begin
      if (b_adv) begin
         height_mem[b_col_ff]   <= new_h;
         velocity_mem[b_col_ff] <= new_v;
      end
      if (a_load) begin
         a_hraw_ff <= height_mem[col_in];
         a_vraw_ff <= velocity_mem[col_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= '0;
      end else if (b_adv) begin
         col_valid_ff[b_col_ff] <= 1'b1;
      end
   end

   // stage a: capture bin and column state
   logic [sbfr_pkg::MAG_W-1:0] a_mag_ff;
   logic                       a_last_ff;

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_mag_ff  <= req_ch.bin_magnitude;
         a_col_ff  <= col_in;
         a_last_ff <= (col_in == CW'(sbfr_pkg::COLUMNS - 1));
         a_hit_ff  <= col_valid_ff[col_in];
      end
   end

   // stage a to b: target, velocity/60 and velocity*factor products
   logic signed [QW-1:0]       a_h, a_v;
   logic [QW-1:0]              a_v_abs;
   logic [2*sbfr_pkg::MAG_W-1:0] tgt_prod;
   logic [2*QW-1:0]            div_prod;
   logic signed [QW+AW:0]      accel_prod;

   assign a_h        = a_hit_ff ? a_hraw_ff : '0;
   assign a_v        = a_hit_ff ? a_vraw_ff : '0;
   assign a_v_abs    = a_v[QW-1] ? QW'(-a_v) : a_v;
   assign tgt_prod   = (2*sbfr_pkg::MAG_W)'(a_mag_ff) * (2*sbfr_pkg::MAG_W)'(sbfr_pkg::RECIP6);
   assign div_prod   = (2*QW)'(a_v_abs) * (2*QW)'(sbfr_pkg::RECIP60);
   assign accel_prod = a_v * $signed({1'b0, accel_ff});

   logic signed [QW-1:0]          b_h_ff;
   logic                          b_v_neg_ff, b_last_ff;
   logic [sbfr_pkg::TGT_W-1:0]    b_tgt_ff;
   logic [sbfr_pkg::DIV60_W-1:0]  b_div_ff;
   logic signed [QW+AW:0]         b_accel_ff;

   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_h_ff     <= a_h;
         b_v_neg_ff <= a_v[QW-1];
         b_tgt_ff   <= tgt_prod[sbfr_pkg::RECIP6_SHIFT +: sbfr_pkg::TGT_W];
         b_div_ff   <= div_prod[sbfr_pkg::RECIP60_SHIFT +: sbfr_pkg::DIV60_W];
         b_accel_ff <= accel_prod;
         b_col_ff   <= a_col_ff;
         b_last_ff  <= a_last_ff;
      end
   end

   // stage b: jump to target or fall by velocity, with saturation
   logic signed [sbfr_pkg::DIV60_W:0] step_q;
   logic signed [QW+1:0]              fall_sum;
   logic signed [QW-1:0]              tgt_q;
   logic                              jump;

   assign step_q   = b_v_neg_ff ? -$signed({1'b0, b_div_ff}) : $signed({1'b0, b_div_ff});
   assign fall_sum = (QW+2)'(b_h_ff) + (QW+2)'(step_q);
   assign tgt_q    = $signed({{(QW-sbfr_pkg::TGT_W){1'b0}}, b_tgt_ff});
   assign jump     = b_h_ff < tgt_q;
   assign new_h    = jump ? tgt_q : sbfr_pkg::sat_q(fall_sum);
   assign new_v    = jump ? -$signed({{(QW-sbfr_pkg::SPEED_W){1'b0}}, speed_ff})
                          : sbfr_pkg::sat_q(b_accel_ff[QW+AW:16]);

   logic signed [QW-1:0] c_h_ff;
   logic                 c_last_ff;

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_h_ff    <= new_h;
         c_col_ff  <= b_col_ff;
         c_last_ff <= b_last_ff;
      end
   end

   // stage c: bar length and column color
   localparam logic [15:0] MAX_LEN = 16'(sbfr_pkg::PANEL_ROWS - 1);
   logic [31:0]           len_prod;
   logic [15:0]           len_whole;
   logic [15:0]           len_clamp;
   logic                  h_pos;
   sbfr_pkg::rgb_type     col_rgb;

   assign h_pos     = !c_h_ff[QW-1] && (c_h_ff != '0);
   assign len_prod  = 32'(c_h_ff[QW-2:0]) * 32'(MAX_LEN);
   assign len_whole = len_prod[31:16];
   assign len_clamp = !h_pos ? '0 : ((len_whole > MAX_LEN) ? MAX_LEN : len_whole);
   assign col_rgb   = sbfr_pkg::rainbow(c_col_ff);

   // result register
   logic [sbfr_pkg::COLIDX_W-1:0] d_col_ff;
   logic [sbfr_pkg::LEN_W-1:0]    d_len_ff;
   sbfr_pkg::rgb_type             d_rgb_ff;
   logic                          d_last_ff;

   always_ff @(posedge clock) begin
      if (c_adv) begin
         d_col_ff  <= sbfr_pkg::COLIDX_W'(c_col_ff);
         d_len_ff  <= len_clamp[sbfr_pkg::LEN_W-1:0];
         d_rgb_ff  <= col_rgb;
         d_last_ff <= c_last_ff;
      end
   end

   assign rsp_ch.valid        = d_valid_ff;
   assign rsp_ch.column_index = d_col_ff;
   assign rsp_ch.bar_length   = d_len_ff;
   assign rsp_ch.red          = d_rgb_ff.red;
   assign rsp_ch.green        = d_rgb_ff.green;
   assign rsp_ch.blue         = d_rgb_ff.blue;
   assign rsp_ch.last_column  = d_last_ff;

   // checks
   `SBFR_ASSERT_NOW(no_col_alias_chk, a_valid_ff && b_valid_ff, a_col_ff != b_col_ff, "two in-flight items share a column")
   `SBFR_ASSERT_NEXT(a_load_chk, a_load, a_valid_ff && (a_col_ff == $past(col_in)), "emitting item did not enter the pipeline")
   `SBFR_ASSERT_NEXT(wb_valid_chk, b_adv, col_valid_ff[$past(b_col_ff)], "written column not marked valid")

endmodule

FILE: bench/sbfr_bar_checker.sv
// column result predictor and checker for the spectrum bar block
module sbfr_bar_checker
   import sbfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sbfr_req_if                   req_mon,
   sbfr_rsp_if                   rsp_mon,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    mismatches,
   output int                    pending
);

   typedef struct {
      logic [COLIDX_W-1:0] column_index;
      logic [LEN_W-1:0]    bar_length;
      rgb_type             color;
      logic                last_column;
   } column_update_type;

   // predicted block state, heights and velocities in signed Q8.16
   longint           col_height[COLUMNS];
   longint           col_velocity[COLUMNS];
   int               bin_pos;
   logic [SPEED_W-1:0] fall_speed;
   logic [ACCEL_W-1:0] fall_accel;

   column_update_type expected_updates[$];

   // clamp into the 25-bit signed range
   function automatic longint clamp_q(input longint v);
      if (v > 64'sd16777215) return 64'sd16777215;
      if (v < -64'sd16777216) return -64'sd16777216;
      return v;
   endfunction

   // six-sector rainbow from the column position
   function automatic rgb_type column_color(input int col);
      int      six_col;
      int      rem;
      int      ramp_up;
      int      ramp_down;
      rgb_type c;
      six_col   = col * 6;
      rem       = six_col % COLUMNS;
      ramp_up   = (255 * rem) / COLUMNS;
      ramp_down = (255 * (COLUMNS - rem)) / COLUMNS;
      case (3'(six_col / COLUMNS))
         SECTOR_RED_YELLOW:   c = '{8'd255, 8'(ramp_up), 8'd0};
         SECTOR_YELLOW_GREEN: c = '{8'(ramp_down), 8'd255, 8'd0};
         SECTOR_GREEN_CYAN:   c = '{8'd0, 8'd255, 8'(ramp_up)};
         SECTOR_CYAN_BLUE:    c = '{8'd0, 8'(ramp_down), 8'd255};
         SECTOR_BLUE_MAGENTA: c = '{8'(ramp_up), 8'd0, 8'd255};
         default:             c = '{8'd255, 8'd0, 8'(ramp_down)};
      endcase
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic clear_model();
      for (int i = 0; i < COLUMNS; i++) begin
         col_height[i]   = 0;
         col_velocity[i] = 0;
      end
      bin_pos    = 0;
      fall_speed = FALL_START_SPEED_RST;
      fall_accel = FALL_ACCEL_FACTOR_RST;
      expected_updates.delete();
      mismatches = 0;
   endtask

   // advance the bin counter and update the column on the last bin of a group
   task automatic predict_bin(input logic [MAG_W-1:0] mag, input logic first);
      int                bin;
      int                col;
      longint            tgt;
      longint            vel;
      longint            len;
      column_update_type upd;
      if (first) bin_pos = 0;
      bin     = (bin_pos < FRAME_BINS) ? bin_pos : 0;
      bin_pos = (bin + 1 >= FRAME_BINS) ? 0 : bin + 1;
      if ((bin % BINS_PER_COLUMN) == BINS_PER_COLUMN - 1) begin
         col = bin / BINS_PER_COLUMN;
         tgt = longint'(mag) / 6;
         if (col_height[col] < tgt) begin
            col_height[col]   = tgt;
            col_velocity[col] = -longint'(fall_speed);
         end else begin
            // gravity: height moves by velocity/60, velocity scales by the factor
            vel               = col_velocity[col];
            col_height[col]   = clamp_q(col_height[col] + vel / 60);
            col_velocity[col] = clamp_q((vel * longint'(fall_accel)) >>> 16);
         end
         len = 0;
         if (col_height[col] > 0) len = (col_height[col] * (PANEL_ROWS - 1)) >>> 16;
         if (len > PANEL_ROWS - 1) len = PANEL_ROWS - 1;
         upd.column_index = COLIDX_W'(col);
         upd.bar_length   = LEN_W'(len);
         upd.color        = column_color(col);
         upd.last_column  = (col == COLUMNS - 1);
         expected_updates.push_back(upd);
      end
   endtask

   // compare one delivered column item with the oldest prediction
   task automatic check_update();
      column_update_type want;
      if (expected_updates.size() == 0) begin
         report_mismatch("column item with nothing predicted, column", rsp_mon.column_index, -1);
      end else begin
         want = expected_updates.pop_front();
         if (rsp_mon.column_index !== want.column_index)
            report_mismatch("column_index", rsp_mon.column_index, want.column_index);
         if (rsp_mon.bar_length !== want.bar_length)
            report_mismatch("bar_length", rsp_mon.bar_length, want.bar_length);
         if (rsp_mon.red !== want.color.red)
            report_mismatch("red", rsp_mon.red, want.color.red);
         if (rsp_mon.green !== want.color.green)
            report_mismatch("green", rsp_mon.green, want.color.green);
         if (rsp_mon.blue !== want.color.blue)
            report_mismatch("blue", rsp_mon.blue, want.color.blue);
         if (rsp_mon.last_column !== want.last_column)
            report_mismatch("last_column", rsp_mon.last_column, want.last_column);
      end
   endtask

   // watch register writes and both channels at every edge
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_FALL_START_SPEED) fall_speed = csr_write_data[SPEED_W-1:0];
            else if (csr_index == CSR_FALL_ACCEL_FACTOR) fall_accel = csr_write_data[ACCEL_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) predict_bin(req_mon.bin_magnitude, req_mon.first_bin);
         if (rsp_mon.valid && rsp_mon.ready) check_update();
      end
      pending <= expected_updates.size();
   end

endmodule

FILE: bench/tb.sv
// top of the spectrum bar testbench: clock, reset, bin stimulus and verdict
module tb;
   import sbfr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE_GAP  = 8;
   localparam int PHASE_BINS  = 190;
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int   mismatches;
   int   pending;
   int   bins_sent;
   int   cycles;
   bit   bursty;
   bit   quiet_tail;
   bit   hold_long;

   sbfr_req_if req_ch();
   sbfr_rsp_if rsp_ch();

   spectrum_bar_falloff_rainbow u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   sbfr_bar_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else if (bursty && !quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // offer one bin item and hold it until taken, then maybe pause
   task automatic send_bin(input logic [MAG_W-1:0] mag, input logic first);
      req_ch.valid         <= 1'b1;
      req_ch.bin_magnitude <= mag;
      req_ch.first_bin     <= first;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bins_sent++;
      if (bursty && !quiet_tail && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // drain all predicted columns and let in-flight bins retire
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   task automatic write_falloff(input logic [CSR_DATA_W-1:0] speed,
                                input logic [CSR_DATA_W-1:0] accel);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_FALL_START_SPEED;
      csr_write_data <= speed;
      @(posedge clock);
      csr_index      <= CSR_FALL_ACCEL_FACTOR;
      csr_write_data <= accel;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // magnitude drawn from a per-frame level, with occasional full-range noise
   function automatic logic [MAG_W-1:0] pick_mag(input int level);
      logic [MAG_W-1:0] m;
      if ($urandom_range(0, 9) == 0) return MAG_W'($urandom);
      case (level)
         0:       m = '0;
         1:       m = MAG_W'($urandom_range(0, 1 << 19));
         2:       m = MAG_W'($urandom);
         default: m = MAG_W'($urandom_range(393216 - 4096, 393216 + 4096));
      endcase
      return m;
   endfunction

   // one stretch of bins: well-formed short or full frames, runs without
   // a frame mark that wrap the counter, or noise with stray frame marks
   task automatic run_frame();
      int kind;
      int level;
      int len;
      kind   = $urandom_range(0, 9);
      level  = $urandom_range(0, 3);
      bursty = ($urandom_range(0, 3) != 0);
      if (kind <= 5) begin
         len = BINS_PER_COLUMN * $urandom_range(2, 16);
         for (int i = 0; i < len; i++) send_bin(pick_mag(level), i == 0);
      end else if (kind <= 7) begin
         for (int i = 0; i < FRAME_BINS; i++) send_bin(pick_mag(level), i == 0);
      end else if (kind == 8) begin
         len = $urandom_range(4, FRAME_BINS);
         for (int i = 0; i < len; i++) send_bin(pick_mag(level), 1'b0);
      end else begin
         len = $urandom_range(1, 20);
         for (int i = 0; i < len; i++)
            send_bin(MAG_W'($urandom), $urandom_range(0, 5) == 0);
      end
   endtask

   task automatic run_phase();
      int stop_at;
      stop_at = bins_sent + PHASE_BINS;
      while (bins_sent < stop_at) run_frame();
   endtask

   // stimulus and verdict
   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.bin_magnitude <= '0;
      req_ch.first_bin     <= 1'b0;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_FALL_START_SPEED;
      csr_write_data <= '0;
      bins_sent  = 0;
      bursty     = 1'b0;
      quiet_tail = 1'b0;
      hold_long  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: column 0 full scale, last bin of a group wins
      send_bin(MAG_MAX, 1'b1);
      send_bin('0, 1'b0);
      send_bin(MAG_MAX, 1'b0);
      send_bin(MAG_MAX, 1'b0);
      // column 1 ends on zero after large bins
      send_bin(MAG_MAX, 1'b0);
      send_bin(MAG_MAX, 1'b0);
      send_bin(MAG_MAX, 1'b0);
      send_bin('0, 1'b0);
      // column 2 right at a full bar, column 3 just below it
      send_bin('0, 1'b0);
      send_bin('0, 1'b0);
      send_bin('0, 1'b0);
      send_bin(24'd393216, 1'b0);
      send_bin('0, 1'b0);
      send_bin('0, 1'b0);
      send_bin('0, 1'b0);
      send_bin(24'd393215, 1'b0);
      // frame restart in the middle of a group
      send_bin(MAG_MAX, 1'b1);
      send_bin(MAG_MAX, 1'b0);
      // column 0 falls under gravity twice
      send_bin('0, 1'b1);
      send_bin('0, 1'b0);
      send_bin('0, 1'b0);
      send_bin('0, 1'b0);
      send_bin(24'd6, 1'b1);
      send_bin('0, 1'b0);
      send_bin('0, 1'b0);
      send_bin('0, 1'b0);

      // random phases over several falloff settings
      run_phase();
      settle();
      write_falloff('0, '0);
      hold_long = 1'b1;
      run_phase();
      settle();
      write_falloff(17'h0FFFF, 17'h1FFFF);
      run_phase();
      settle();
      write_falloff(17'h1ABCD, 17'h10000);
      run_phase();
      settle();
      write_falloff(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      run_phase();
      settle();
      write_falloff(17'(FALL_START_SPEED_RST), FALL_ACCEL_FACTOR_RST);
      quiet_tail = 1'b1;
      run_phase();

      settle();
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/sbfr_pkg.sv
src/sbfr_if.sv
src/spectrum_bar_falloff_rainbow.sv
bench/sbfr_bar_checker.sv
bench/tb.sv
